/* sv/indexed_max_degree_queue_defines.svh */
// Assertion macros for the indexed max-degree queue.
`ifndef INDEXED_MAX_DEGREE_QUEUE_DEFINES_SVH
`define INDEXED_MAX_DEGREE_QUEUE_DEFINES_SVH

// Check on every clock edge outside reset.
`define IMDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define IMDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/imdq_pkg.sv */
package imdq_pkg;

  localparam int CAPACITY    = 256;
  localparam int NODE_BITS   = 20;
  localparam int DEGREE_BITS = 20;
  localparam int FIELD_BITS  = 20;
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;
  localparam int SLOT_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

  typedef logic [OP_BITS-1:0]     opcode_t;
  typedef logic [STATUS_BITS-1:0] status_t;
  typedef logic [FIELD_BITS-1:0]  field_t;
  typedef logic [NODE_BITS-1:0]   node_t;
  typedef logic [DEGREE_BITS-1:0] degree_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  localparam opcode_t OP_ADD    = 2'd0;
  localparam opcode_t OP_UPDATE = 2'd1;
  localparam opcode_t OP_POP    = 2'd2;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam count_t COUNT_FULL = count_t'(CAPACITY);
  localparam slot_t  SLOT_LAST  = slot_t'(CAPACITY - 1);

  typedef struct packed {
    node_t   node;
    degree_t degree;
  } entry_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage

/* sv/imdq_ifs.sv */
interface imdq_req_if;
  import imdq_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  field_t  node_id;
  field_t  degree;

  modport source (output valid, output opcode, output node_id, output degree, input ready);
  modport sink (input valid, input opcode, input node_id, input degree, output ready);
endinterface

interface imdq_rsp_if;
  import imdq_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    flag;
  field_t  popped_node;
  field_t  popped_degree;

  modport source (output valid, output status, output flag, output popped_node,
                  output popped_degree, input ready);
  modport sink (input valid, input status, input flag, input popped_node,
                input popped_degree, output ready);
endinterface

/* sv/imdq_ctrl.sv */
module imdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output imdq_pkg::dp_cmd_t cmd,
  input  imdq_pkg::dp_stat_t stat
);
  import imdq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_APPLY = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);
  assign cmd.start = req_valid && (state == S_IDLE);
  assign cmd.scan  = (state == S_SCAN);
  assign cmd.apply = (state == S_APPLY);

endmodule

/* sv/imdq_datapath.sv */
module imdq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  imdq_pkg::dp_cmd_t  cmd,
  output imdq_pkg::dp_stat_t stat,
  input  imdq_pkg::opcode_t  opcode,
  input  imdq_pkg::field_t   node_id,
  input  imdq_pkg::field_t   degree,
  output imdq_pkg::status_t  status,
  output logic               flag,
  output imdq_pkg::field_t   popped_node,
  output imdq_pkg::field_t   popped_degree
);
  import imdq_pkg::*;

  entry_t mem [CAPACITY];

  logic [CAPACITY-1:0] valid;
  count_t              count;

  slot_t  addr;
  logic   rd_en;
  slot_t  rd_slot;
  logic   rd_bit;
  entry_t rd_data;

  opcode_t op;
  node_t   op_node;
  degree_t op_degree;

  logic    hit;
  slot_t   hit_slot;
  degree_t hit_degree;
  logic    free_ok;
  slot_t   free_slot;
  logic    best_ok;
  slot_t   best_slot;
  entry_t  best;

  logic    wr_en;
  slot_t   wr_slot;
  entry_t  wr_data;
  logic    ins;
  logic    rem;
  status_t res_status_next;
  logic    res_flag_next;
  node_t   res_node_next;
  degree_t res_degree_next;

  status_t res_status;
  logic    res_flag;
  node_t   res_node;
  degree_t res_degree;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr <= '0;
    end else if (cmd.scan) begin
      addr <= addr + 1'b1;
    end
  end

  assign stat.scan_last = (addr == SLOT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en <= 1'b0;
    end else begin
      rd_en <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= mem[addr];
      rd_slot <= addr;
      rd_bit  <= valid[addr];
    end
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op        <= opcode;
      op_node   <= node_id[NODE_BITS-1:0];
      op_degree <= degree[DEGREE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit     <= 1'b0;
      free_ok <= 1'b0;
      best_ok <= 1'b0;
    end else if (cmd.start) begin
      hit     <= 1'b0;
      free_ok <= 1'b0;
      best_ok <= 1'b0;
    end else if (rd_en) begin
      if (rd_bit) begin
        if (rd_data.node == op_node) begin
          hit        <= 1'b1;
          hit_slot   <= rd_slot;
          hit_degree <= rd_data.degree;
        end
        if (!best_ok ||
            {rd_data.degree, rd_data.node} > {best.degree, best.node}) begin
          best_ok   <= 1'b1;
          best_slot <= rd_slot;
          best      <= rd_data;
        end
      end else if (!free_ok) begin
        free_ok   <= 1'b1;
        free_slot <= rd_slot;
      end
    end
  end

  always_comb begin
    wr_en           = 1'b0;
    wr_slot         = hit_slot;
    wr_data         = '{node: op_node, degree: op_degree};
    ins             = 1'b0;
    rem             = 1'b0;
    res_status_next = ST_DONE;
    res_flag_next   = 1'b0;
    res_node_next   = '0;
    res_degree_next = '0;
    if (cmd.apply) begin
      case (op)
        OP_ADD, OP_UPDATE: begin
          if (hit) begin
            wr_en         = 1'b1;
            res_flag_next = (op == OP_ADD) ? (hit_degree != op_degree) : 1'b1;
          end else if (free_ok && (count != COUNT_FULL)) begin
            wr_en         = 1'b1;
            wr_slot       = free_slot;
            ins           = 1'b1;
            res_flag_next = (op == OP_ADD);
          end else begin
            res_status_next = ST_FULL;
          end
        end
        OP_POP: begin
          if (best_ok) begin
            rem             = 1'b1;
            res_node_next   = best.node;
            res_degree_next = best.degree;
          end else begin
            res_status_next = ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      if (ins) begin
        valid[free_slot] <= 1'b1;
        count            <= count + 1'b1;
      end
      if (rem) begin
        valid[best_slot] <= 1'b0;
        count            <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_status <= res_status_next;
      res_flag   <= res_flag_next;
      res_node   <= res_node_next;
      res_degree <= res_degree_next;
    end
  end

  assign status        = res_status;
  assign flag          = res_flag;
  assign popped_node   = field_t'(res_node);
  assign popped_degree = field_t'(res_degree);

endmodule

/* sv/indexed_max_degree_queue.sv */
// Indexed max-degree queue: holds up to CAPACITY (256) node entries, each node at most
// once, and serves add, update-degree and pop-maximum requests, one response per
// request. Every transaction sweeps the whole entry memory through its single read
// port, one slot per cycle, then steps through drain and apply states before the
// response is offered and held until ready; one request is in flight at a time
// and req.ready is low until its response is taken. Entry occupancy is kept in
// flip-flops cleared by reset, so the block is ready in the first cycle after
// reset with no clearing pass.
module indexed_max_degree_queue (
  input logic       clk,
  input logic       rst,
  imdq_req_if.sink  req,
  imdq_rsp_if.source rsp
);
  import imdq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  imdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  imdq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (req.opcode),
    .node_id       (req.node_id),
    .degree        (req.degree),
    .status        (rsp.status),
    .flag          (rsp.flag),
    .popped_node   (rsp.popped_node),
    .popped_degree (rsp.popped_degree)
  );

endmodule

/* sv/imdq_checker.sv */
`include "indexed_max_degree_queue_defines.svh"

module imdq_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input imdq_pkg::status_t rsp_status,
  input logic              rsp_flag,
  input imdq_pkg::field_t  rsp_popped_node,
  input imdq_pkg::field_t  rsp_popped_degree
);
  import imdq_pkg::*;

  `IMDQ_ASSERT(a_one_in_flight, (req_valid && req_ready) |=> !req_ready, "request taken while busy")
  `IMDQ_ASSERT(a_no_overlap, rsp_valid |-> !req_ready, "request open while response pending")
  `IMDQ_ASSERT(a_error_clean, (rsp_valid && (rsp_status != ST_DONE)) |-> (!rsp_flag && (rsp_popped_node == '0) && (rsp_popped_degree == '0)), "error response carries data")
  `IMDQ_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid, "response dropped before taken")
  `IMDQ_ASSERT_ALWAYS(a_reset_idle, rst |=> (!rsp_valid && req_ready), "not idle after reset")

endmodule

bind indexed_max_degree_queue imdq_checker u_imdq_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_flag          (rsp.flag),
  .rsp_popped_node   (rsp.popped_node),
  .rsp_popped_degree (rsp.popped_degree)
);
